FILE: sv/bbsp_pkg.sv
// Package: shared types, constants and state encodings for the path search.
package bbsp_pkg;

  localparam int unsigned MaxCitiesDef  = 16;
  localparam int unsigned WeightBitsDef = 16;
  localparam int unsigned DistBits      = 24;
  localparam int unsigned CityBits      = 4;
  localparam int unsigned CountBits     = 5;
  localparam int unsigned EdgeBits      = 16;
  localparam int unsigned CfgAddrBits   = 2;
  localparam int unsigned CfgDataBits   = 24;

  typedef enum logic [1:0] {
    CFG_CITY_COUNT    = 2'd0,
    CFG_ORIGIN_CITY   = 2'd1,
    CFG_SHORTEST_EDGE = 2'd2,
    CFG_INITIAL_BOUND = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_WAIT,
    ST_EVAL,
    ST_LEAF,
    ST_UP,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_wr;
    logic init;
    logic eval;
    logic leaf;
    logic up;
    logic emit_clr;
    logic emit_step;
    logic out_load;
    logic out_empty;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic at_leaf;
    logic exhausted;
    logic at_root;
    logic emit_done;
    logic found;
  } ctrl_stat_t;

endpackage

FILE: sv/bbsp_if.sv
// Interfaces: input item channel and result channel.
interface bbsp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] from_city;
  logic [3:0] to_city;
  logic [15:0] weight;
  modport source (output valid, mode, from_city, to_city, weight, input ready);
  modport sink (input valid, mode, from_city, to_city, weight, output ready);
endinterface

interface bbsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  tour_position;
  logic [3:0]  tour_city;
  logic [23:0] tour_distance;
  logic        found;
  logic        last;
  modport source (output valid, tour_position, tour_city, tour_distance, found, last,
                  input ready);
  modport sink (input valid, tour_position, tour_city, tour_distance, found, last,
                output ready);
endinterface

FILE: sv/bbsp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module bbsp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: sv/bbsp_ctrl.sv
// Controller: sequences loads, the search loop and result emission.
module bbsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_ready,
  input  logic                 out_busy,
  output bbsp_pkg::ctrl_cmd_t  cmd,
  input  bbsp_pkg::ctrl_stat_t stat
);
  import bbsp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && in_mode) state_next = ST_INIT;
      ST_INIT:  state_next = ST_FETCH;
      ST_FETCH: begin
        if (stat.at_leaf) state_next = ST_LEAF;
        else if (stat.exhausted) state_next = ST_UP;
        else state_next = ST_WAIT;
      end
      ST_WAIT:  state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_FETCH;
      ST_LEAF:  state_next = ST_UP;
      ST_UP: begin
        if (!stat.at_root) state_next = ST_FETCH;
        else if (stat.found) state_next = ST_EMIT;
        else state_next = ST_EMPTY;
      end
      ST_EMIT:  if (!out_busy && stat.emit_done) state_next = ST_IDLE;
      ST_EMPTY: if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_wr  = in_valid && !in_mode;
        cmd.init     = in_valid && in_mode;
      end
      ST_INIT:  cmd.emit_clr = 1'b1;
      ST_FETCH: ;
      ST_WAIT:  ;
      ST_EVAL:  cmd.eval = 1'b1;
      ST_LEAF:  cmd.leaf = 1'b1;
      ST_UP:    cmd.up = !stat.at_root;
      ST_EMIT: begin
        cmd.out_load  = !out_busy;
        cmd.emit_step = !out_busy;
      end
      ST_EMPTY: begin
        cmd.out_load  = !out_busy;
        cmd.out_empty = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/bbsp_dp.sv
// Datapath: weight memory, route and stacks, prune test and result register.
module bbsp_dp #(
  parameter int unsigned MaxCities  = bbsp_pkg::MaxCitiesDef,
  parameter int unsigned WeightBits = bbsp_pkg::WeightBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bbsp_pkg::CityBits-1:0] from_city,
  input  logic [bbsp_pkg::CityBits-1:0] to_city,
  input  logic [bbsp_pkg::EdgeBits-1:0] weight,
  input  logic [bbsp_pkg::CountBits-1:0] city_count,
  input  logic [bbsp_pkg::CityBits-1:0] origin_city,
  input  logic [bbsp_pkg::EdgeBits-1:0] shortest_edge,
  input  logic [bbsp_pkg::DistBits-1:0] initial_bound,
  input  bbsp_pkg::ctrl_cmd_t           cmd,
  output bbsp_pkg::ctrl_stat_t          stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bbsp_pkg::CityBits-1:0] tour_position,
  output logic [bbsp_pkg::CityBits-1:0] tour_city,
  output logic [bbsp_pkg::DistBits-1:0] tour_distance,
  output logic                          found,
  output logic                          last
);
  import bbsp_pkg::*;

  localparam int unsigned IdxBits = $clog2(MaxCities);
  localparam int unsigned DepBits = $clog2(MaxCities + 1);
  localparam int unsigned AdrBits = 2 * IdxBits;
  localparam int unsigned SumBits = DistBits + EdgeBits + DepBits + 1;

  logic [IdxBits-1:0] route [MaxCities];
  logic [IdxBits-1:0] best_route [MaxCities];
  logic [DepBits-1:0] choice [MaxCities];
  logic [DistBits-1:0] part_dist [MaxCities];
  logic [DepBits-1:0] depth;
  logic [DepBits-1:0] n_eff;
  logic [DistBits-1:0] best;
  logic                found_any;
  logic [DepBits-1:0]  emit_idx;
  logic [WeightBits-1:0] w_rd;
  logic [IdxBits-1:0]  cand_pos;
  logic [DepBits-1:0]  rem;

  // Effective run parameters
  logic [DepBits-1:0] n_calc;
  logic [IdxBits-1:0] s_calc;
  always_comb begin
    if (city_count < CountBits'(2)) n_calc = DepBits'(2);
    else if (32'(city_count) > MaxCities) n_calc = DepBits'(MaxCities);
    else n_calc = DepBits'(city_count);
    s_calc = (32'(origin_city) < 32'(n_calc)) ? IdxBits'(origin_city) : '0;
  end

  // Weight memory: load address or search lookup
  logic                wr_ok;
  logic [AdrBits-1:0]  wr_addr, rd_addr;
  logic [DepBits-1:0]  pos_wide;
  assign wr_ok    = cmd.load_wr && (32'(from_city) < MaxCities) && (32'(to_city) < MaxCities);
  assign wr_addr  = {IdxBits'(from_city), IdxBits'(to_city)};
  assign pos_wide = depth + DepBits'(1) + choice[depth[IdxBits-1:0]];
  assign cand_pos = pos_wide[IdxBits-1:0];
  assign rd_addr  = {route[depth[IdxBits-1:0]], route[cand_pos]};

  bbsp_ram #(.Width(WeightBits), .Depth(1 << AdrBits)) u_weights (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data (WeightBits'(weight)),
    .rd_addr (rd_addr),
    .rd_data (w_rd)
  );

  // Prune test: the product is registered before the add and compare
  logic [EdgeBits+DepBits-1:0] slack;
  logic [SumBits-1:0] nd, bnd;
  always_ff @(posedge clk) begin
    slack <= shortest_edge * (rem - DepBits'(1));
  end
  assign rem = n_eff - DepBits'(1) - depth;
  assign nd  = SumBits'(part_dist[depth[IdxBits-1:0]]) + SumBits'(w_rd);
  assign bnd = nd + SumBits'(slack);

  assign stat.at_leaf   = (rem == '0);
  assign stat.exhausted = (choice[depth[IdxBits-1:0]] >= rem);
  assign stat.at_root   = (depth == '0);
  assign stat.emit_done = (emit_idx == n_eff - DepBits'(1));
  assign stat.found     = found_any;

  // Search state
  logic [IdxBits-1:0] d1, up_pos;
  logic [DepBits-1:0] dm1, up_wide;
  assign d1      = IdxBits'(depth + DepBits'(1));
  assign dm1     = depth - DepBits'(1);
  assign up_wide = depth + choice[dm1[IdxBits-1:0]];
  assign up_pos  = up_wide[IdxBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      found_any <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (cmd.init) begin
        depth     <= '0;
        found_any <= 1'b0;
        n_eff     <= n_calc;
        best      <= initial_bound;
        part_dist[0] <= '0;
        choice[0] <= '0;
        // identity order with the origin swapped into the first place
        for (int i = 0; i < MaxCities; i++) begin
          if (i == 0) route[i] <= s_calc;
          else if (IdxBits'(i) == s_calc) route[i] <= '0;
          else route[i] <= IdxBits'(i);
        end
      end
      if (cmd.eval) begin
        if (bnd >= SumBits'(best)) begin
          choice[depth[IdxBits-1:0]] <= choice[depth[IdxBits-1:0]] + DepBits'(1);
        end else begin
          if (cand_pos != d1) begin
            route[cand_pos] <= route[d1];
            route[d1]       <= route[cand_pos];
          end
          part_dist[d1]   <= nd[DistBits-1:0];
          choice[d1]      <= '0;
          depth           <= depth + DepBits'(1);
        end
      end
      if (cmd.leaf && part_dist[depth[IdxBits-1:0]] < best) begin
        best      <= part_dist[depth[IdxBits-1:0]];
        found_any <= 1'b1;
        for (int i = 0; i < MaxCities; i++) begin
          best_route[i] <= route[i];
        end
      end
      if (cmd.up) begin
        if (up_pos != IdxBits'(depth)) begin
          route[IdxBits'(depth)] <= route[up_pos];
          route[up_pos]          <= route[IdxBits'(depth)];
        end
        choice[dm1[IdxBits-1:0]] <= choice[dm1[IdxBits-1:0]] + DepBits'(1);
        depth <= dm1;
      end
      if (cmd.emit_clr) emit_idx <= '0;
      if (cmd.emit_step) emit_idx <= emit_idx + DepBits'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        tour_position <= '0;
        tour_city     <= '0;
        tour_distance <= '0;
        found         <= 1'b0;
        last          <= 1'b1;
      end else begin
        tour_position <= CityBits'(emit_idx);
        tour_city     <= CityBits'(best_route[emit_idx[IdxBits-1:0]]);
        tour_distance <= best;
        found         <= 1'b1;
        last          <= stat.emit_done;
      end
    end
  end
endmodule

FILE: sv/branch_bound_shortest_path_tour.sv
// Top level: exact shortest open path search by branch and bound.
// Usage: the input channel carries load items (mode 0) that write one weight
// of the distance matrix, one per cycle while idle, and run items (mode 1)
// that start a depth-first search from the origin city over the first
// city_count cities. Configuration registers are written through
// cfg_we/cfg_addr/cfg_data; the user must do so only while the block is idle.
// The block itself does not enforce this. A run passes an init state, then
// each candidate step goes through weight memory read, registered
// shortest_edge product and prune compare, each complete path through fetch,
// compare with the best and backtrack, and an exhausted level is left through
// fetch and backtrack; the count of steps depends on the graph and the pruning.
// The result channel then carries one transfer per city of the best path,
// or a single transfer with found low; last marks the final one.
// While a run is in progress the input is not ready.
// Reset returns the controller to idle, clears the output valid and sets the
// config registers to defaults; matrix contents are undefined until loaded.
// A stalled receiver holds the result register and the emission waits.
module branch_bound_shortest_path_tour #(
  parameter int unsigned MaxCities  = bbsp_pkg::MaxCitiesDef,
  parameter int unsigned WeightBits = bbsp_pkg::WeightBitsDef
) (
  input  logic                             clk,
  input  logic                             rst,
  bbsp_in_if.sink                          in_ch,
  bbsp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bbsp_pkg::CfgAddrBits-1:0] cfg_addr,
  input  logic [bbsp_pkg::CfgDataBits-1:0] cfg_data
);
  import bbsp_pkg::*;

  logic [CountBits-1:0] city_count;
  logic [CityBits-1:0]  origin_city;
  logic [EdgeBits-1:0]  shortest_edge;
  logic [DistBits-1:0]  initial_bound;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count    <= CountBits'(2);
      origin_city   <= '0;
      shortest_edge <= '0;
      initial_bound <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_CITY_COUNT:    city_count    <= cfg_data[CountBits-1:0];
        CFG_ORIGIN_CITY:   origin_city   <= cfg_data[CityBits-1:0];
        CFG_SHORTEST_EDGE: shortest_edge <= cfg_data[EdgeBits-1:0];
        CFG_INITIAL_BOUND: initial_bound <= cfg_data[DistBits-1:0];
        default: ;
      endcase
    end
  end

  bbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .out_busy (out_ch.valid && !out_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bbsp_dp #(.MaxCities(MaxCities), .WeightBits(WeightBits)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .from_city     (in_ch.from_city),
    .to_city       (in_ch.to_city),
    .weight        (in_ch.weight),
    .city_count    (city_count),
    .origin_city   (origin_city),
    .shortest_edge (shortest_edge),
    .initial_bound (initial_bound),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .tour_position (out_ch.tour_position),
    .tour_city     (out_ch.tour_city),
    .tour_distance (out_ch.tour_distance),
    .found         (out_ch.found),
    .last          (out_ch.last)
  );

`ifndef ASSERT_OFF
  // The input is never ready while a search step (eval, leaf or up) is issued
  a_no_accept_during_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval || cmd.leaf || cmd.up) |-> !in_ch.ready)
    else $error("input ready during search");
  // A result load never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !cmd.out_load)
    else $error("result overwritten");
  // An empty result is always the last one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.found) |-> out_ch.last)
    else $error("not-found result without last");
`endif
endmodule
